// ===== src/wds_pkg.sv =====
// Shared types and constants for the waypoint differential steering block.
// Holds the sequencer states, the register indexes and the CORDIC arctangent table.
// Used by wds_cordic, wds_steer, the top module and the testbench; depends on nothing.
package wds_pkg;

    localparam int HEAD_W     = 17;
    localparam int ERR_W      = 18;
    localparam int SPD_W      = 8;
    localparam int DIST_W     = 17;
    localparam int RADIUS_W   = 16;
    localparam int CFG_W      = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int Z_W        = 26;
    localparam int PRE_SHIFT  = 12;

    localparam logic signed [Z_W-1:0]   QUARTER_TURN_Z = 26'sd5898240;
    localparam logic signed [ERR_W-1:0] HALF_TURN      = 18'sd23040;
    localparam logic signed [ERR_W-1:0] FULL_TURN      = 18'sd46080;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd200;
    localparam logic [CFG_W-1:0]    BASE_RST   = 7'd20;
    localparam logic [CFG_W-1:0]    LIMIT_RST  = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_BASE   = 2'd1,
        CFG_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_START,
        S_RUN,
        S_ERR,
        S_SPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_err;
        logic load_spd;
    } t_steer_ctrl;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic signed [Z_W-1:0] atan_step(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/wds_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Takes the squared distance and returns its floor root.
// Depends on nothing beyond its parameter.
module wds_isqrt #(
    parameter int SQ_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_n,
    output logic              o_busy,
    output logic [SQ_W/2-1:0] o_root
);

    localparam int RT_W = SQ_W / 2;

    logic            r_busy;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] n_n;
    logic [SQ_W-1:0] n_res;
    logic [SQ_W:0]   trial;
    logic            take;

    always_comb begin
        trial = {1'b0, r_res} + {1'b0, r_bit};
        take  = ({1'b0, r_n} >= trial);
        if (take) begin
            n_n   = r_n - trial[SQ_W-1:0];
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_n   = r_n;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            r_n   <= n_n;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[RT_W-1:0];

endmodule

// ===== src/wds_cordic.sv =====
// Iterative CORDIC vectoring unit that returns atan2(dy, dx) in 1/65536 degree.
// One micro-rotation per cycle through a shared shifter and adders.
// Depends on wds_pkg for the angle width and the arctangent table.
module wds_cordic #(
    parameter int IN_W  = 17,
    parameter int STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [IN_W-1:0]        i_dx,
    input  logic signed [IN_W-1:0]        i_dy,
    output logic                          o_busy,
    output logic signed [wds_pkg::Z_W-1:0] o_z
);

    localparam int XY_W  = IN_W + wds_pkg::PRE_SHIFT + 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_zero;
    logic signed [XY_W-1:0]        r_x;
    logic signed [XY_W-1:0]        r_y;
    logic signed [wds_pkg::Z_W-1:0] r_z;
    logic signed [XY_W-1:0]        n_x;
    logic signed [XY_W-1:0]        n_y;
    logic signed [wds_pkg::Z_W-1:0] n_z;
    logic signed [XY_W-1:0]        x0;
    logic signed [XY_W-1:0]        y0;
    logic signed [XY_W-1:0]        px;
    logic signed [XY_W-1:0]        py;
    logic signed [wds_pkg::Z_W-1:0] pz;
    logic signed [XY_W-1:0]        xs;
    logic signed [XY_W-1:0]        ys;
    logic signed [wds_pkg::Z_W-1:0] step_z;

    // Vectors in the left half plane are first turned by a quarter turn.
    always_comb begin
        x0 = {{2{i_dx[IN_W-1]}}, i_dx, {wds_pkg::PRE_SHIFT{1'b0}}};
        y0 = {{2{i_dy[IN_W-1]}}, i_dy, {wds_pkg::PRE_SHIFT{1'b0}}};
        px = x0;
        py = y0;
        pz = '0;
        if (x0[XY_W-1]) begin
            if (!y0[XY_W-1]) begin
                px = y0;
                py = -x0;
                pz = wds_pkg::QUARTER_TURN_Z;
            end else begin
                px = -y0;
                py = x0;
                pz = -wds_pkg::QUARTER_TURN_Z;
            end
        end
    end

    always_comb begin
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        step_z = wds_pkg::atan_step(5'(r_cnt));
        if (!r_y[XY_W-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + step_z;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - step_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= px;
            r_y    <= py;
            r_z    <= pz;
            r_zero <= (i_dx == '0) && (i_dy == '0);
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_z    = r_zero ? '0 : r_z;

endmodule

// ===== src/wds_steer.sv =====
// Heading error and wheel speed stage of the steering block.
// Rounds the CORDIC angle, wraps the error and derives the clamped wheel speeds.
// Depends on wds_pkg for widths, turn constants and the control struct.
module wds_steer (
    input  logic                             i_clk,
    input  wds_pkg::t_steer_ctrl             i_ctrl,
    input  logic signed [wds_pkg::HEAD_W-1:0] i_heading,
    input  logic signed [wds_pkg::Z_W-1:0]    i_z,
    input  logic [wds_pkg::CFG_W-1:0]         i_base,
    input  logic [wds_pkg::CFG_W-1:0]         i_limit,
    output logic signed [wds_pkg::ERR_W-1:0]  o_err,
    output logic signed [wds_pkg::SPD_W-1:0]  o_left,
    output logic signed [wds_pkg::SPD_W-1:0]  o_right
);

    localparam int V_W        = 20;
    localparam int U_W        = 11;
    localparam int P_W        = 22;
    localparam int Q_W        = 10;
    localparam int S_W        = 12;
    localparam int DIV_SHIFT  = 7;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV_SCALE  = 384;
    localparam int DIV3_MUL   = 683;
    localparam int ROUND_SH   = 9;
    localparam int ROUND_ADD  = 256;

    logic signed [wds_pkg::ERR_W-1:0] r_err;
    logic signed [wds_pkg::SPD_W-1:0] r_left;
    logic signed [wds_pkg::SPD_W-1:0] r_right;
    logic signed [wds_pkg::Z_W-1:0]   z_rnd;
    logic signed [wds_pkg::ERR_W-1:0] angle;
    logic signed [wds_pkg::ERR_W-1:0] err_sum;
    logic signed [wds_pkg::ERR_W-1:0] n_err;
    logic [V_W-1:0]                   b_full;
    logic signed [V_W-1:0]            v_left;
    logic signed [V_W-1:0]            v_right;

    // Divides by 384 with truncation toward zero, then clamps to the limit.
    function automatic logic signed [wds_pkg::SPD_W-1:0] speed_q(
        input logic signed [V_W-1:0]    v,
        input logic [wds_pkg::CFG_W-1:0] lim
    );
        logic [V_W-1:0]        mag;
        logic [U_W-1:0]        u;
        logic [P_W-1:0]        prod;
        logic [Q_W-1:0]        q;
        logic signed [S_W-1:0] qs;
        logic signed [S_W-1:0] lims;
        logic signed [S_W-1:0] res;
        mag  = v[V_W-1] ? V_W'(-v) : V_W'(v);
        u    = U_W'(mag >> DIV_SHIFT);
        prod = P_W'(u) * P_W'(DIV3_MUL);
        q    = Q_W'(prod >> DIV3_SHIFT);
        qs   = $signed({2'b00, q});
        if (v[V_W-1]) begin
            qs = -qs;
        end
        lims = $signed({5'b00000, lim});
        if (qs > lims) begin
            res = lims;
        end else if (qs < -lims) begin
            res = -lims;
        end else begin
            res = qs;
        end
        return wds_pkg::SPD_W'(res);
    endfunction

    always_comb begin
        z_rnd   = i_z + wds_pkg::Z_W'(ROUND_ADD);
        angle   = wds_pkg::ERR_W'(z_rnd >>> ROUND_SH);
        err_sum = wds_pkg::ERR_W'(i_heading) + angle;
        n_err   = (err_sum > wds_pkg::HALF_TURN) ? err_sum - wds_pkg::FULL_TURN : err_sum;
        b_full  = V_W'(i_base) * V_W'(DIV_SCALE);
        v_left  = $signed(b_full) - V_W'(r_err);
        v_right = $signed(b_full) + V_W'(r_err);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_err) begin
            r_err <= n_err;
        end
        if (i_ctrl.load_spd) begin
            r_left  <= speed_q(v_left, i_limit);
            r_right <= speed_q(v_right, i_limit);
        end
    end

    assign o_err   = r_err;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== src/waypoint_differential_steering_unit.sv =====
// Waypoint steering for a differential-drive robot, built on wds_isqrt, wds_cordic, wds_steer.
// The time to a result is set by the longer of the square-root loop (one root bit per cycle)
// and the CORDIC loop beside it, and loading the result waits while the output is stalled.
// One item at a time: the next input can be taken in the cycle after the result is loaded.
// Synchronous active-low reset clears the sequencer, held wheel speeds and output valid,
// and loads the register defaults.
module waypoint_differential_steering_unit #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_x,
    input  logic signed [COORD_WIDTH-1:0]         i_robot_y,
    input  logic signed [wds_pkg::HEAD_W-1:0]     i_robot_heading,
    input  logic signed [COORD_WIDTH-1:0]         i_target_x,
    input  logic signed [COORD_WIDTH-1:0]         i_target_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_advance,
    output logic signed [wds_pkg::SPD_W-1:0]      o_speed_left,
    output logic signed [wds_pkg::SPD_W-1:0]      o_speed_right,
    output logic [wds_pkg::DIST_W-1:0]            o_distance,
    output logic signed [wds_pkg::ERR_W-1:0]      o_heading_error,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int IN_W  = COORD_WIDTH + 1;
    localparam int PR_W  = 2 * IN_W;
    localparam int SQ_W  = (PR_W > 64) ? 64 : PR_W;
    localparam int RT_W  = SQ_W / 2;
    localparam int CMP_W = (RT_W > wds_pkg::RADIUS_W) ? RT_W : wds_pkg::RADIUS_W;

    wds_pkg::t_state      r_state;
    wds_pkg::t_state      n_state;
    wds_pkg::t_steer_ctrl steer_ctrl;

    logic signed [IN_W-1:0]              r_dx;
    logic signed [IN_W-1:0]              r_dy;
    logic signed [wds_pkg::HEAD_W-1:0]   r_hd;
    logic [SQ_W-1:0]                     r_sx;
    logic [SQ_W-1:0]                     r_sy;
    logic                                r_near;
    logic signed [wds_pkg::SPD_W-1:0]    r_held_l;
    logic signed [wds_pkg::SPD_W-1:0]    r_held_r;
    logic                                r_out_valid;
    logic                                r_advance;
    logic signed [wds_pkg::SPD_W-1:0]    r_out_l;
    logic signed [wds_pkg::SPD_W-1:0]    r_out_r;
    logic [wds_pkg::DIST_W-1:0]          r_dist;
    logic signed [wds_pkg::ERR_W-1:0]    r_err_out;
    logic [wds_pkg::RADIUS_W-1:0]        r_radius;
    logic [wds_pkg::CFG_W-1:0]           r_base;
    logic [wds_pkg::CFG_W-1:0]           r_limit;

    logic                                accept;
    logic                                start;
    logic                                load_sx;
    logic                                load_sy;
    logic                                load_near;
    logic                                load_out;
    logic signed [IN_W-1:0]              dx;
    logic signed [IN_W-1:0]              dy;
    logic signed [IN_W-1:0]              sq_src;
    logic [IN_W-1:0]                     sq_op;
    logic [PR_W-1:0]                     prod;
    logic [SQ_W:0]                       sq_sum;
    logic [SQ_W-1:0]                     sq_val;
    logic                                sqrt_busy;
    logic [RT_W-1:0]                     root;
    logic                                cordic_busy;
    logic signed [wds_pkg::Z_W-1:0]      z;
    logic signed [wds_pkg::ERR_W-1:0]    err;
    logic signed [wds_pkg::SPD_W-1:0]    spd_l;
    logic signed [wds_pkg::SPD_W-1:0]    spd_r;

    always_comb begin
        dx     = IN_W'(i_robot_x) - IN_W'(i_target_x);
        dy     = IN_W'(i_robot_y) - IN_W'(i_target_y);
        sq_src = (r_state == wds_pkg::S_SQX) ? r_dx : r_dy;
        sq_op  = sq_src[IN_W-1] ? IN_W'(-sq_src) : IN_W'(sq_src);
        prod   = {{IN_W{1'b0}}, sq_op} * {{IN_W{1'b0}}, sq_op};
        sq_sum = {1'b0, r_sx} + {1'b0, r_sy};
        sq_val = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wds_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = wds_pkg::S_SQX;
                end
            end
            wds_pkg::S_SQX:   n_state = wds_pkg::S_SQY;
            wds_pkg::S_SQY:   n_state = wds_pkg::S_START;
            wds_pkg::S_START: n_state = wds_pkg::S_RUN;
            wds_pkg::S_RUN: begin
                if (!sqrt_busy && !cordic_busy) begin
                    n_state = wds_pkg::S_ERR;
                end
            end
            wds_pkg::S_ERR:   n_state = wds_pkg::S_SPD;
            wds_pkg::S_SPD:   n_state = wds_pkg::S_DONE;
            wds_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = wds_pkg::S_IDLE;
                end
            end
            default: n_state = wds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall             = (r_state != wds_pkg::S_IDLE);
        accept              = (r_state == wds_pkg::S_IDLE) && i_valid;
        load_sx             = (r_state == wds_pkg::S_SQX);
        load_sy             = (r_state == wds_pkg::S_SQY);
        start               = (r_state == wds_pkg::S_START);
        load_near           = (r_state == wds_pkg::S_ERR);
        steer_ctrl.load_err = (r_state == wds_pkg::S_ERR);
        steer_ctrl.load_spd = (r_state == wds_pkg::S_SPD);
        load_out            = (r_state == wds_pkg::S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= wds_pkg::RADIUS_RST;
            r_base   <= wds_pkg::BASE_RST;
            r_limit  <= wds_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wds_pkg::CFG_RADIUS: r_radius <= i_cfg_data;
                wds_pkg::CFG_BASE:   r_base   <= i_cfg_data[wds_pkg::CFG_W-1:0];
                wds_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[wds_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx <= dx;
            r_dy <= dy;
            r_hd <= i_robot_heading;
        end
        if (load_sx) begin
            r_sx <= prod[SQ_W-1:0];
        end
        if (load_sy) begin
            r_sy <= prod[SQ_W-1:0];
        end
        if (load_near) begin
            r_near <= (CMP_W'(root) < CMP_W'(r_radius));
        end
    end

    // Held wheel speeds only move when the waypoint has not been reached.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                if (!r_near) begin
                    r_held_l <= spd_l;
                    r_held_r <= spd_r;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_advance <= r_near;
            r_dist    <= wds_pkg::DIST_W'(root);
            if (r_near) begin
                r_out_l   <= r_held_l;
                r_out_r   <= r_held_r;
                r_err_out <= '0;
            end else begin
                r_out_l   <= spd_l;
                r_out_r   <= spd_r;
                r_err_out <= err;
            end
        end
    end

    wds_isqrt #(
        .SQ_W (SQ_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_n     (sq_val),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    wds_cordic #(
        .IN_W  (IN_W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_busy  (cordic_busy),
        .o_z     (z)
    );

    wds_steer u_steer (
        .i_clk     (i_clk),
        .i_ctrl    (steer_ctrl),
        .i_heading (r_hd),
        .i_z       (z),
        .i_base    (r_base),
        .i_limit   (r_limit),
        .o_err     (err),
        .o_left    (spd_l),
        .o_right   (spd_r)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_advance       = r_advance;
    assign o_speed_left    = r_out_l;
    assign o_speed_right   = r_out_r;
    assign o_distance      = r_dist;
    assign o_heading_error = r_err_out;

endmodule

// ===== tb/tb_waypoint_differential_steering_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for waypoint_differential_steering_unit: directed and random poses
// against an internal steering predictor. Depends on wds_pkg and the block's RTL only.
module tb_waypoint_differential_steering_unit;

    localparam int COORD_W = 16;
    localparam int STEPS = 16;
    localparam int CLK_PERIOD = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 2 * COORD_W + 16;
    localparam int SEGMENTS = 13;
    localparam int SEGMENT_LEN = 100;
    localparam int MAX_GAP = 40;
    localparam int HEAD_MAX = 46080;
    localparam longint SPEED_DIV = 384;
    localparam longint Z_QUARTER = 90 * 65536;
    localparam longint ATAN_Z [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int COORD_EDGE [0:3] = '{-32768, 32767, 0, -1};

    typedef struct {
        logic signed [COORD_W-1:0]         rx;
        logic signed [COORD_W-1:0]         ry;
        logic signed [wds_pkg::HEAD_W-1:0] heading;
        logic signed [COORD_W-1:0]         tx;
        logic signed [COORD_W-1:0]         ty;
    } t_pose;

    typedef struct {
        logic                             advance;
        logic signed [wds_pkg::SPD_W-1:0] left;
        logic signed [wds_pkg::SPD_W-1:0] right;
        logic [wds_pkg::DIST_W-1:0]       dist_mm;
        logic signed [wds_pkg::ERR_W-1:0] herr;
    } t_steer;

    class t_steer_checker;
        t_steer pending_steer [$];
        logic [wds_pkg::RADIUS_W-1:0] radius;
        logic [wds_pkg::CFG_W-1:0] base;
        logic [wds_pkg::CFG_W-1:0] limit;
        logic signed [wds_pkg::SPD_W-1:0] held_left;
        logic signed [wds_pkg::SPD_W-1:0] held_right;
        int mismatches;
        int checked;
        int arrivals;

        function new();
            radius = wds_pkg::RADIUS_RST;
            base = wds_pkg::BASE_RST;
            limit = wds_pkg::LIMIT_RST;
            held_left = '0;
            held_right = '0;
            mismatches = 0;
            checked = 0;
            arrivals = 0;
        endfunction

        function void set_reg(wds_pkg::t_cfg_idx idx, logic [wds_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wds_pkg::CFG_RADIUS: radius = data[wds_pkg::RADIUS_W-1:0];
                wds_pkg::CFG_BASE:   base = data[wds_pkg::CFG_W-1:0];
                wds_pkg::CFG_LIMIT:  limit = data[wds_pkg::CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Bearing of (dx, dy) in 1/65536 degree by CORDIC vectoring.
        function longint bearing_z(longint dy, longint dx);
            longint x, y, z, t, xs, ys;
            if (dx == 0 && dy == 0) return 0;
            x = dx * 4096;
            y = dy * 4096;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = Z_QUARTER;
                end else begin
                    x = -y;
                    y = t;
                    z = -Z_QUARTER;
                end
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Z[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Z[i];
                end
            end
            return z;
        endfunction

        function longint clip_speed(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void note_pose(t_pose p);
            longint dx, dy, err, b, lim, left, right;
            longint unsigned dist_mm;
            t_steer e;
            dx = longint'(p.rx) - longint'(p.tx);
            dy = longint'(p.ry) - longint'(p.ty);
            dist_mm = root_floor(longint'(dx * dx + dy * dy));
            err = 0;
            if (dist_mm < radius) begin
                e.advance = 1'b1;
                arrivals++;
            end else begin
                b = longint'(base) * SPEED_DIV;
                lim = longint'(limit);
                err = longint'(p.heading) + ((bearing_z(dy, dx) + 256) >>> 9);
                if (err > longint'(wds_pkg::HALF_TURN)) err = err - longint'(wds_pkg::FULL_TURN);
                left = clip_speed((b - err) / SPEED_DIV, lim);
                right = clip_speed((b + err) / SPEED_DIV, lim);
                held_left = left[wds_pkg::SPD_W-1:0];
                held_right = right[wds_pkg::SPD_W-1:0];
                e.advance = 1'b0;
            end
            e.left = held_left;
            e.right = held_right;
            e.dist_mm = dist_mm[wds_pkg::DIST_W-1:0];
            e.herr = err[wds_pkg::ERR_W-1:0];
            pending_steer.push_back(e);
        endfunction

        function void check_steer(t_steer got);
            t_steer e;
            if (pending_steer.size() == 0) begin
                $error("result transfer with no expected result pending");
                mismatches++;
                return;
            end
            e = pending_steer.pop_front();
            checked++;
            if (got.advance !== e.advance) begin
                $error("advance: expected %0d, actual %0d", e.advance, got.advance);
                mismatches++;
            end
            if (got.left !== e.left) begin
                $error("speed_left: expected %0d, actual %0d", e.left, got.left);
                mismatches++;
            end
            if (got.right !== e.right) begin
                $error("speed_right: expected %0d, actual %0d", e.right, got.right);
                mismatches++;
            end
            if (got.dist_mm !== e.dist_mm) begin
                $error("distance: expected %0d, actual %0d", e.dist_mm, got.dist_mm);
                mismatches++;
            end
            if (got.herr !== e.herr) begin
                $error("heading_error: expected %0d, actual %0d", e.herr, got.herr);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [COORD_W-1:0] i_robot_x = '0;
    logic signed [COORD_W-1:0] i_robot_y = '0;
    logic signed [wds_pkg::HEAD_W-1:0] i_robot_heading = '0;
    logic signed [COORD_W-1:0] i_target_x = '0;
    logic signed [COORD_W-1:0] i_target_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_advance;
    logic signed [wds_pkg::SPD_W-1:0] o_speed_left;
    logic signed [wds_pkg::SPD_W-1:0] o_speed_right;
    logic [wds_pkg::DIST_W-1:0] o_distance;
    logic signed [wds_pkg::ERR_W-1:0] o_heading_error;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [wds_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [wds_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    t_steer_checker sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int poses_sent = 0;
    int settings_used = 1;
    int cycle_count = 0;
    logic [wds_pkg::RADIUS_W-1:0] cur_radius = wds_pkg::RADIUS_RST;

    waypoint_differential_steering_unit #(
        .COORD_WIDTH(COORD_W),
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_robot_x(i_robot_x),
        .i_robot_y(i_robot_y),
        .i_robot_heading(i_robot_heading),
        .i_target_x(i_target_x),
        .i_target_y(i_target_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_advance(o_advance),
        .o_speed_left(o_speed_left),
        .o_speed_right(o_speed_right),
        .o_distance(o_distance),
        .o_heading_error(o_heading_error),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_steer got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.advance = o_advance;
            got.left = o_speed_left;
            got.right = o_speed_right;
            got.dist_mm = o_distance;
            got.herr = o_heading_error;
            sb.check_steer(got);
        end
        i_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_pose pose_at(int rx, int ry, int h, int tx, int ty);
        t_pose p;
        p.rx = rx[COORD_W-1:0];
        p.ry = ry[COORD_W-1:0];
        p.heading = h[wds_pkg::HEAD_W-1:0];
        p.tx = tx[COORD_W-1:0];
        p.ty = ty[COORD_W-1:0];
        return p;
    endfunction

    function automatic int fit_coord(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_pose roll_pose();
        int rx, ry, tx, ty, h, span, pick;
        tx = int'($urandom_range(0, 65535)) - 32768;
        ty = int'($urandom_range(0, 65535)) - 32768;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            span = (cur_radius < 16'd65533) ? int'(cur_radius) + 2 : 65535;
            rx = fit_coord(tx + int'($urandom_range(0, 2 * span)) - span);
            ry = fit_coord(ty + int'($urandom_range(0, 2 * span)) - span);
        end else if (pick < 45) begin
            rx = COORD_EDGE[$urandom_range(0, 3)];
            ry = COORD_EDGE[$urandom_range(0, 3)];
            tx = COORD_EDGE[$urandom_range(0, 3)];
            ty = COORD_EDGE[$urandom_range(0, 3)];
        end else begin
            rx = int'($urandom_range(0, 65535)) - 32768;
            ry = int'($urandom_range(0, 65535)) - 32768;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) h = HEAD_MAX;
        else if (pick == 1) h = -HEAD_MAX;
        else h = int'($urandom_range(0, 2 * HEAD_MAX)) - HEAD_MAX;
        return pose_at(rx, ry, h, tx, ty);
    endfunction

    task automatic drive_pose(input t_pose p);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_robot_x <= p.rx;
        i_robot_y <= p.ry;
        i_robot_heading <= p.heading;
        i_target_x <= p.tx;
        i_target_y <= p.ty;
        do @(posedge i_clk); while (o_stall);
        sb.note_pose(p);
        poses_sent++;
    endtask

    task automatic put_reg(input wds_pkg::t_cfg_idx idx,
                           input logic [wds_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Called in the step of the last input transfer; waits for the block to drain first.
    task automatic write_regs(input logic [wds_pkg::RADIUS_W-1:0] radius,
                              input logic [wds_pkg::CFG_W-1:0] base,
                              input logic [wds_pkg::CFG_W-1:0] limit);
        logic [wds_pkg::CFG_DATA_W-wds_pkg::CFG_W-1:0] junk;
        i_valid <= 1'b0;
        while (sb.pending_steer.size() != 0) @(posedge i_clk);
        put_reg(wds_pkg::CFG_RADIUS, radius);
        junk = (wds_pkg::CFG_DATA_W - wds_pkg::CFG_W)'($urandom);
        put_reg(wds_pkg::CFG_BASE, {junk, base});
        junk = (wds_pkg::CFG_DATA_W - wds_pkg::CFG_W)'($urandom);
        put_reg(wds_pkg::CFG_LIMIT, {junk, limit});
        i_cfg_valid <= 1'b0;
        cur_radius = radius;
        settings_used++;
    endtask

    task automatic run_segment();
        logic [wds_pkg::RADIUS_W-1:0] radius;
        logic [wds_pkg::CFG_W-1:0] base, limit;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) radius = wds_pkg::RADIUS_W'($urandom_range(0, 1000));
        else if (pick < 8) radius = wds_pkg::RADIUS_W'($urandom);
        else radius = (pick == 8) ? '0 : '1;
        base = wds_pkg::CFG_W'($urandom);
        limit = wds_pkg::CFG_W'($urandom);
        if ($urandom_range(0, 4) == 0) base = ($urandom_range(0, 1) != 0) ? '1 : '0;
        if ($urandom_range(0, 4) == 0) limit = ($urandom_range(0, 1) != 0) ? '1 : '0;
        write_regs(radius, base, limit);
        repeat (SEGMENT_LEN) drive_pose(roll_pose());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_pose(pose_at(0, 0, 0, 0, 0));
        drive_pose(pose_at(32767, 32767, HEAD_MAX, -32768, -32768));
        drive_pose(pose_at(-32768, -32768, -HEAD_MAX, 32767, 32767));
        drive_pose(pose_at(32767, -32768, 0, -32768, 32767));
        drive_pose(pose_at(-32768, 32767, 0, 32767, -32768));
        drive_pose(pose_at(200, 0, 0, 0, 0));
        drive_pose(pose_at(199, 0, 0, 0, 0));
        drive_pose(pose_at(120, -160, 0, 0, 0));
        drive_pose(pose_at(0, 1000, 0, 0, 0));
        drive_pose(pose_at(0, -1000, 0, 0, 0));
        drive_pose(pose_at(-1000, 0, 0, 0, 0));
        drive_pose(pose_at(-1000, -1, 0, 0, 0));
        drive_pose(pose_at(1000, 0, 23040, 0, 0));
        drive_pose(pose_at(1000, 0, 23041, 0, 0));
        drive_pose(pose_at(-1000, 0, HEAD_MAX, 0, 0));
        drive_pose(pose_at(-1000, -1, -HEAD_MAX, 0, 0));

        write_regs('0, '1, '1);
        drive_pose(pose_at(5, 5, 0, 5, 5));
        drive_pose(pose_at(-1000, 0, HEAD_MAX, 0, 0));
        drive_pose(pose_at(1000, 0, -30000, 0, 0));
        drive_pose(pose_at(1, 0, 0, 0, 0));

        write_regs('1, '0, '0);
        drive_pose(pose_at(32767, 0, 1234, -32768, 0));
        drive_pose(pose_at(32767, 0, 0, -32767, 0));
        drive_pose(pose_at(-32768, -32768, -HEAD_MAX, 32767, 32767));

        write_regs(16'd10, '0, '1);
        drive_pose(pose_at(-1000, 0, 0, 0, 0));
        drive_pose(pose_at(0, 1000, -HEAD_MAX, 0, 0));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            run_segment();
        end

        i_valid <= 1'b0;
        while (sb.pending_steer.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d poses under %0d register settings and four idle patterns.",
                 poses_sent, settings_used);
        $display("Checked %0d results, %0d of them arrivals, in %0d cycles.",
                 sb.checked, sb.arrivals, cycle_count);
        if (sb.mismatches == 0 && sb.pending_steer.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
